// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Clocked property that also holds across reset.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ===== hdl/nsls_pkg.sv =====
// ----------------------------------------------------------------------------
// nsls_pkg
// Types, constants and helpers for the nearest seed label search.
// ----------------------------------------------------------------------------
package nsls_pkg;

    localparam int MAX_SEEDS_DEF = 64;
    localparam int COORD_W       = 20;
    localparam int SLOT_W        = 6;
    localparam int LABEL_W       = 8;
    localparam int COUNT_W       = 7;
    localparam int DIST_W        = 42;
    localparam int DIFF_W        = COORD_W + 1;
    localparam int SQ_W          = 2 * COORD_W + 1;
    localparam int QUEUE_DEPTH   = 2;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // word index of the seed_count register (paddr[2])
    localparam logic REG_SEED_COUNT = 1'b0;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic               op;
        logic [SLOT_W-1:0]  slot;
        t_coord             point_x;
        t_coord             point_y;
        logic [LABEL_W-1:0] region_label;
    } t_in_item;

    typedef struct packed {
        logic [LABEL_W-1:0] nearest_label;
        logic [SLOT_W-1:0]  nearest_slot;
        logic               table_empty;
        logic [DIST_W-1:0]  best_distance;
    } t_out_item;

    typedef struct packed {
        t_coord             x;
        t_coord             y;
        logic [LABEL_W-1:0] label;
    } t_seed;

    typedef struct packed {
        logic              is_query;
        logic              wr_en;
        logic [SLOT_W-1:0] slot;
        t_seed             seed;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_back_state;

    // |a - b| without overflow
    function automatic logic [DIFF_W-1:0] abs_diff(input t_coord a, input t_coord b);
        logic signed [DIFF_W-1:0] d;
        d = DIFF_W'(a) - DIFF_W'(b);
        return d[DIFF_W-1] ? $unsigned(-d) : $unsigned(d);
    endfunction

endpackage

// ===== hdl/nsls_front.sv =====
// ----------------------------------------------------------------------------
// nsls_front
// Takes input items and turns them into load or query commands for the queue.
// ----------------------------------------------------------------------------
module nsls_front #(
    parameter int MAX_SEEDS = nsls_pkg::MAX_SEEDS_DEF
) (
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  nsls_pkg::t_in_item i_in_item,
    input  logic               i_q_full,
    output logic               o_q_push,
    output nsls_pkg::t_cmd     o_q_cmd
);

    assign o_in_ready = !i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;

    always_comb begin
        o_q_cmd.is_query   = (i_in_item.op == nsls_pkg::OP_QUERY);
        // loads beyond the table are dropped here
        o_q_cmd.wr_en      = (i_in_item.op == nsls_pkg::OP_LOAD) &&
                             (32'(i_in_item.slot) < 32'(MAX_SEEDS));
        o_q_cmd.slot       = i_in_item.slot;
        o_q_cmd.seed.x     = i_in_item.point_x;
        o_q_cmd.seed.y     = i_in_item.point_y;
        o_q_cmd.seed.label = i_in_item.region_label;
    end

endmodule

// ===== hdl/nsls_queue.sv =====
// ----------------------------------------------------------------------------
// nsls_queue
// Short FIFO of commands between the front and the search engine.
// ----------------------------------------------------------------------------
module nsls_queue #(
    parameter int DEPTH = nsls_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  nsls_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output nsls_pkg::t_cmd o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    nsls_pkg::t_cmd r_q [DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count,  n_count;
    logic           w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_q[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hdl/nsls_back.sv =====
// ----------------------------------------------------------------------------
// nsls_back
// Seed table and search engine: applies loads, scans the table for queries
// through a read / difference / square / compare pipeline.
// ----------------------------------------------------------------------------
module nsls_back #(
    parameter int MAX_SEEDS = nsls_pkg::MAX_SEEDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  nsls_pkg::t_cmd                i_cmd,
    output logic                          o_cmd_pop,
    input  logic [nsls_pkg::COUNT_W-1:0]  i_seed_count,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output nsls_pkg::t_out_item           o_out_item
);

    localparam int IW = $clog2(MAX_SEEDS);
    localparam int CW = $clog2(MAX_SEEDS + 1);

    // seed table
    nsls_pkg::t_seed r_mem [MAX_SEEDS];
    nsls_pkg::t_seed r_rd_data;

    nsls_pkg::t_back_state r_state, n_state;

    logic            w_mem_we;
    logic            w_start;
    logic            w_load_out;
    logic            w_issue;
    logic            w_scan_done;
    logic [CW-1:0]   w_n_sat;

    // query context
    nsls_pkg::t_coord r_qx, r_qy;
    logic [CW-1:0]    r_n;
    logic [CW-1:0]    r_idx;
    logic             r_empty;

    // pipeline
    logic                             r_p1_v, r_p2_v, r_p3_v;
    logic [IW-1:0]                    r_p1_slot, r_p2_slot, r_p3_slot;
    logic [nsls_pkg::LABEL_W-1:0]     r_p2_label, r_p3_label;
    logic [nsls_pkg::DIFF_W-1:0]      r_p2_dx, r_p2_dy;
    logic [nsls_pkg::SQ_W-1:0]        r_p3_sx, r_p3_sy;
    logic [2*nsls_pkg::DIFF_W-1:0]    w_sq_x, w_sq_y;
    logic [nsls_pkg::DIST_W-1:0]      w_dist;

    // running best
    logic                             r_have;
    logic [nsls_pkg::DIST_W-1:0]      r_best_dist;
    logic [IW-1:0]                    r_best_slot;
    logic [nsls_pkg::LABEL_W-1:0]     r_best_label;

    logic                             r_out_valid;
    nsls_pkg::t_out_item              r_out_item;

    assign w_n_sat = (32'(i_seed_count) > 32'(MAX_SEEDS)) ? CW'(MAX_SEEDS)
                                                           : CW'(i_seed_count);
    assign w_issue     = (r_state == nsls_pkg::ST_SCAN) && (r_idx != r_n);
    assign w_scan_done = (r_idx == r_n) && !r_p1_v && !r_p2_v && !r_p3_v;

    assign w_sq_x = r_p2_dx * r_p2_dx;
    assign w_sq_y = r_p2_dy * r_p2_dy;
    assign w_dist = nsls_pkg::DIST_W'(r_p3_sx) + nsls_pkg::DIST_W'(r_p3_sy);

    always_comb begin
        n_state    = r_state;
        o_cmd_pop  = 1'b0;
        w_mem_we   = 1'b0;
        w_start    = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            nsls_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.is_query) begin
                        w_start = 1'b1;
                        n_state = (w_n_sat == '0) ? nsls_pkg::ST_DONE : nsls_pkg::ST_SCAN;
                    end else begin
                        w_mem_we = i_cmd.wr_en;
                    end
                end
            end
            nsls_pkg::ST_SCAN: begin
                if (w_scan_done) begin
                    n_state = nsls_pkg::ST_DONE;
                end
            end
            nsls_pkg::ST_DONE: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    w_load_out = 1'b1;
                    n_state    = nsls_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = nsls_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nsls_pkg::ST_IDLE;
            r_p1_v      <= 1'b0;
            r_p2_v      <= 1'b0;
            r_p3_v      <= 1'b0;
            r_idx       <= '0;
            r_n         <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p1_v  <= w_issue;
            r_p2_v  <= r_p1_v;
            r_p3_v  <= r_p2_v;
            if (w_start) begin
                r_n    <= w_n_sat;
                r_idx  <= '0;
                r_have <= 1'b0;
            end else if (w_issue) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_p3_v) begin
                r_have <= 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // table write and registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[IW'(i_cmd.slot)] <= i_cmd.seed;
        end
        r_rd_data <= r_mem[r_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_qx    <= i_cmd.seed.x;
            r_qy    <= i_cmd.seed.y;
            r_empty <= (w_n_sat == '0);
        end
        r_p1_slot  <= r_idx[IW-1:0];
        r_p2_slot  <= r_p1_slot;
        r_p2_label <= r_rd_data.label;
        r_p2_dx    <= nsls_pkg::abs_diff(r_qx, r_rd_data.x);
        r_p2_dy    <= nsls_pkg::abs_diff(r_qy, r_rd_data.y);
        r_p3_slot  <= r_p2_slot;
        r_p3_label <= r_p2_label;
        r_p3_sx    <= w_sq_x[nsls_pkg::SQ_W-1:0];
        r_p3_sy    <= w_sq_y[nsls_pkg::SQ_W-1:0];
        // strict less-than keeps the lowest slot on ties
        if (r_p3_v && (!r_have || (w_dist < r_best_dist))) begin
            r_best_dist  <= w_dist;
            r_best_slot  <= r_p3_slot;
            r_best_label <= r_p3_label;
        end
        if (w_load_out) begin
            if (r_empty) begin
                r_out_item.nearest_label <= '0;
                r_out_item.nearest_slot  <= '0;
                r_out_item.table_empty   <= 1'b1;
                r_out_item.best_distance <= '0;
            end else begin
                r_out_item.nearest_label <= r_best_label;
                r_out_item.nearest_slot  <= (nsls_pkg::SLOT_W)'(r_best_slot);
                r_out_item.table_empty   <= 1'b0;
                r_out_item.best_distance <= r_best_dist;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== hdl/nearest_seed_label_search.sv =====
// ----------------------------------------------------------------------------
// nearest_seed_label_search
// Table of 2-D seeds with labels; answers nearest-seed queries.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready / i_in_item): op 0 loads one seed
// slot and gives no result, op 1 queries the seed nearest the given point.
// Output channel (o_out_valid / i_out_ready / o_out_item): one result per
// query, in order. Config: APB port, seed_count at byte address 0.
// Items pass through a two-entry command queue to the search engine. A load
// is written into the table as the engine takes it. A query reads one table
// slot per cycle through a single table read port, scanning the first
// seed_count slots (at most MAX_SEEDS); the engine takes no further item
// until that query's result has been loaded into the output register.
// Reset empties the queue, drops any result and clears seed_count to zero;
// the table content stays undefined until loaded.
// When the receiver stalls, the result waits in the output register, the
// engine holds the next result and the queue fills, then o_in_ready drops.
// ----------------------------------------------------------------------------
module nearest_seed_label_search #(
    parameter int MAX_SEEDS = nsls_pkg::MAX_SEEDS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  nsls_pkg::t_in_item                 i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output nsls_pkg::t_out_item                o_out_item,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [nsls_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [nsls_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [nsls_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    logic [nsls_pkg::COUNT_W-1:0] r_seed_count;
    logic                         w_cfg_wr;
    logic                         w_q_full, w_q_push, w_q_valid, w_q_pop;
    nsls_pkg::t_cmd               w_q_in, w_q_out;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready &&
                      (paddr[2] == nsls_pkg::REG_SEED_COUNT);
    assign prdata   = (paddr[2] == nsls_pkg::REG_SEED_COUNT) ?
                      nsls_pkg::APB_DATA_W'(r_seed_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_count <= '0;
        end else if (w_cfg_wr) begin
            r_seed_count <= pwdata[nsls_pkg::COUNT_W-1:0];
        end
    end

    nsls_front #(
        .MAX_SEEDS (MAX_SEEDS)
    ) u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_cmd    (w_q_in)
    );

    nsls_queue #(
        .DEPTH (nsls_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_out)
    );

    nsls_back #(
        .MAX_SEEDS (MAX_SEEDS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_q_valid),
        .i_cmd        (w_q_out),
        .o_cmd_pop    (w_q_pop),
        .i_seed_count (r_seed_count),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item)
    );

endmodule

// ===== hdl/nsls_checker.sv =====
// ----------------------------------------------------------------------------
// nsls_checker
// Port-level checks on the nearest seed label search, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nsls_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input nsls_pkg::t_out_item             i_out_item,
    input logic [nsls_pkg::APB_DATA_W-1:0] i_prdata
);

    // reset drops any pending result
    `ASSERT_CLK_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !i_out_valid)

    // a stalled result holds its transfer
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_item))

    // empty-table results carry zero label, slot and distance
    `ASSERT_CLK(a_empty_zero, i_clk, i_rst_n, i_out_valid && i_out_item.table_empty |-> (i_out_item.nearest_label == '0) && (i_out_item.nearest_slot == '0) && (i_out_item.best_distance == '0))

    // read data never shows bits above the count register
    `ASSERT_CLK(a_prdata_width, i_clk, i_rst_n, (i_prdata >> nsls_pkg::COUNT_W) == '0)

endmodule

bind nearest_seed_label_search nsls_checker u_nsls_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_item  (o_out_item),
    .i_prdata    (prdata)
);
